// ===== src/gravity_euler_body_step_core_macros.svh =====
// Assertion macros for the gravity step core checkers.
`ifndef GRAVITY_EULER_BODY_STEP_CORE_MACROS_SVH
`define GRAVITY_EULER_BODY_STEP_CORE_MACROS_SVH

// same-cycle implication
`define GEBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gebs assertion failed");

// next-cycle implication
`define GEBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gebs assertion failed");

`endif

// ===== src/gebs_pkg.sv =====
// Shared types and constants of the gravity step core.
package gebs_pkg;

	localparam int COORD_W   = 32;
	localparam int FRAC_BITS = 16;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV,
		OP_SQRT
	} op_t;

	typedef struct packed {
		logic       start;
		op_t        op;
		logic [6:0] count;
	} unit_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_SQRT,
		ST_R2,
		ST_FDIV,
		ST_FMUL,
		ST_ADIV,
		ST_VEL,
		ST_POS,
		ST_OUT
	} state_t;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_ZERO = 2'd1;
	localparam logic [1:0] STAT_SAT  = 2'd2;

	localparam logic CMD_RESTART = 1'b0;

	localparam logic [2:0] REG_GRAV   = 3'd0;
	localparam logic [2:0] REG_DT     = 3'd1;
	localparam logic [2:0] REG_POS_X  = 3'd2;
	localparam logic [2:0] REG_POS_Y  = 3'd3;
	localparam logic [2:0] REG_POS_Z  = 3'd4;
	localparam logic [2:0] REG_VEL_X  = 3'd5;
	localparam logic [2:0] REG_VEL_Y  = 3'd6;
	localparam logic [2:0] REG_VEL_Z  = 3'd7;

	// iteration counts of the shared unit
	localparam logic [6:0] CNT_SQ   = 7'd33;
	localparam logic [6:0] CNT_SQRT = 7'd34;
	localparam logic [6:0] CNT_R2   = 7'd34;
	localparam logic [6:0] CNT_FDIV = 7'(64 + 2 * FRAC_BITS);
	localparam logic [6:0] CNT_FMUL = 7'd33;
	localparam logic [6:0] CNT_ADIV = 7'd97;

endpackage

// ===== src/gebs_iter_unit.sv =====
// Bit-serial multiply, restoring divide and square root on one shared adder.
module gebs_iter_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gebs_pkg::unit_req_t  req,
	input  logic [127:0]         opa,
	input  logic [127:0]         opb,
	output logic                 done,
	output logic [127:0]         res
);
	import gebs_pkg::*;

	logic         busy_q, done_q;
	op_t          op_q;
	logic [6:0]   cnt_q;
	logic [127:0] acc_q, sh_q, mb_q, quo_q;
	logic [127:0] x, y;
	logic         sub;
	logic [128:0] sum;
	logic         ge;

	always_comb begin
		case (op_q)
			OP_DIV: begin
				x   = {acc_q[126:0], sh_q[127]};
				y   = mb_q;
				sub = 1'b1;
			end
			OP_SQRT: begin
				x   = {acc_q[125:0], sh_q[127:126]};
				y   = {quo_q[125:0], 2'b01};
				sub = 1'b1;
			end
			default: begin
				x   = acc_q;
				y   = sh_q;
				sub = 1'b0;
			end
		endcase
		sum = {1'b0, x} + {1'b0, (sub ? ~y : y)} + 129'(sub);
		ge  = sum[128];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= req.count;
				op_q   <= req.op;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			acc_q <= '0;
			quo_q <= '0;
			sh_q  <= opa;
			mb_q  <= opb;
		end else if (busy_q) begin
			case (op_q)
				OP_DIV: begin
					acc_q <= ge ? sum[127:0] : x;
					quo_q <= {quo_q[126:0], ge};
					sh_q  <= {sh_q[126:0], 1'b0};
				end
				OP_SQRT: begin
					acc_q <= ge ? sum[127:0] : x;
					quo_q <= {quo_q[126:0], ge};
					sh_q  <= {sh_q[125:0], 2'b00};
				end
				default: begin
					if (mb_q[0]) acc_q <= sum[127:0];
					sh_q <= {sh_q[126:0], 1'b0};
					mb_q <= {1'b0, mb_q[127:1]};
				end
			endcase
		end
	end

	assign done = done_q;
	assign res  = (op_q == OP_MUL) ? acc_q : quo_q;

endmodule

// ===== src/gravity_euler_body_step_core.sv =====
// Top level: one body under point-mass gravity, semi-implicit Euler (position uses the new velocity), Q16.16.
// A restart item offers its result in the cycle after acceptance; a step item runs
// on the one-bit-per-cycle shared unit (three squares, a root, r^2, the force
// division, then per axis a product and a division), or ends after the root when the
// distance is zero.
// Throughput: one item at a time; s_tready is low from acceptance until the result
// transaction completes. arst_n clears state, configuration and control registers at once.
module gravity_euler_body_step_core (
	input  logic          clk,
	input  logic          arst_n,
	// slave stream
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [127:0]  s_tdata,   // attractor_x, attractor_y, attractor_z, attractor_mass
	input  logic [0:0]    s_tuser,   // command
	// master stream
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [191:0]  m_tdata,   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
	output logic [1:0]    m_tuser,   // status
	// APB
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import gebs_pkg::*;

	localparam logic [71:0] DELTA_LIM = 72'(1) << (COORD_W + 1);
	localparam logic signed [35:0] V_MAX = 36'sd2147483647;
	localparam logic signed [35:0] V_MIN = -36'sd2147483648;
	localparam logic signed [41:0] P_MAX = 42'sd2147483647;
	localparam logic signed [41:0] P_MIN = -42'sd2147483648;

	// configuration
	logic [31:0] grav_q;
	logic [7:0]  dt_q;
	logic [31:0] init_q [6];

	// body state
	logic [31:0] pos_q [3];
	logic [31:0] vel_q [3];

	// work registers
	state_t       state_q, state_d;
	logic [1:0]   ax_q;
	logic         pend_q;
	logic [32:0]  d_q [3];
	logic [63:0]  km_q;
	logic [65:0]  s_q;
	logic [33:0]  r_q;
	logic [67:0]  r2_q;
	logic [63:0]  f_q;
	logic [96:0]  prod_q;
	logic [63:0]  a_q;
	logic         sat_q;
	logic [1:0]   status_q;

	// shared unit
	unit_req_t    ureq;
	logic [127:0] uopa, uopb, ures;
	logic         udone;

	logic         accept, wr_en;
	logic [2:0]   widx;
	logic [32:0]  dax, absd;
	logic [71:0]  dprod;
	logic [33:0]  delta;
	logic signed [35:0] vsum;
	logic [31:0]  vnew;
	logic         vsat;
	logic signed [40:0] pm;
	logic signed [41:0] psum;
	logic [31:0]  pnew;
	logic         psat;

	gebs_iter_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ureq),
		.opa    (uopa),
		.opb    (uopb),
		.done   (udone),
		.res    (ures)
	);

	// APB register file
	assign pready = 1'b1;
	assign widx   = paddr[4:2];
	assign wr_en  = psel && penable && pwrite && pready;

	always_comb begin
		case (widx)
			REG_GRAV:  prdata = grav_q;
			REG_DT:    prdata = {24'd0, dt_q};
			REG_POS_X: prdata = init_q[0];
			REG_POS_Y: prdata = init_q[1];
			REG_POS_Z: prdata = init_q[2];
			REG_VEL_X: prdata = init_q[3];
			REG_VEL_Y: prdata = init_q[4];
			REG_VEL_Z: prdata = init_q[5];
			default:   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= 32'd65536;
			dt_q   <= 8'd5;
			for (int i = 0; i < 6; i++) init_q[i] <= '0;
		end else if (wr_en) begin
			case (widx)
				REG_GRAV:  grav_q    <= pwdata;
				REG_DT:    dt_q      <= pwdata[7:0];
				REG_POS_X: init_q[0] <= pwdata;
				REG_POS_Y: init_q[1] <= pwdata;
				REG_POS_Z: init_q[2] <= pwdata;
				REG_VEL_X: init_q[3] <= pwdata;
				REG_VEL_Y: init_q[4] <= pwdata;
				REG_VEL_Z: init_q[5] <= pwdata;
				default: ;
			endcase
		end
	end

	// per-axis datapath
	assign accept = s_tvalid && s_tready;
	assign dax    = d_q[ax_q];
	assign absd   = dax[32] ? 33'(-dax) : dax;

	always_comb begin
		// velocity: v +/- min(a*dt, 2^33), clamped
		dprod = 72'(a_q) * 72'(dt_q);
		delta = (dprod > DELTA_LIM) ? DELTA_LIM[33:0] : dprod[33:0];
		vsum  = dax[32] ? (36'(signed'(vel_q[ax_q])) - signed'({2'b00, delta}))
		                : (36'(signed'(vel_q[ax_q])) + signed'({2'b00, delta}));
		vsat  = (vsum > V_MAX) || (vsum < V_MIN);
		vnew  = (vsum > V_MAX) ? V_MAX[31:0] : ((vsum < V_MIN) ? V_MIN[31:0] : vsum[31:0]);
		// position: p + v'*dt, clamped
		pm    = 41'(signed'(vel_q[ax_q])) * signed'({33'd0, dt_q});
		psum  = 42'(signed'(pos_q[ax_q])) + 42'(pm);
		psat  = (psum > P_MAX) || (psum < P_MIN);
		pnew  = (psum > P_MAX) ? P_MAX[31:0] : ((psum < P_MIN) ? P_MIN[31:0] : psum[31:0]);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_d = (s_tuser[0] == CMD_RESTART) ? ST_OUT : ST_SQ;
			ST_SQ:   if (udone && ax_q == 2'd2) state_d = ST_SQRT;
			ST_SQRT: if (udone) state_d = (ures[33:0] == '0) ? ST_OUT : ST_R2;
			ST_R2:   if (udone) state_d = ST_FDIV;
			ST_FDIV: if (udone) state_d = ST_FMUL;
			ST_FMUL: if (udone) state_d = ST_ADIV;
			ST_ADIV: if (udone) state_d = ST_VEL;
			ST_VEL:  state_d = (ax_q == 2'd2) ? ST_POS : ST_FMUL;
			ST_POS:  if (ax_q == 2'd2) state_d = ST_OUT;
			ST_OUT:  if (m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and unit requests
	always_comb begin
		s_tready   = (state_q == ST_IDLE);
		m_tvalid   = (state_q == ST_OUT);
		ureq.start = 1'b0;
		ureq.op    = OP_MUL;
		ureq.count = CNT_SQ;
		uopa       = '0;
		uopb       = '0;
		case (state_q)
			ST_SQ: begin
				ureq.start = !pend_q;
				uopa       = 128'(absd);
				uopb       = 128'(absd);
			end
			ST_SQRT: begin
				ureq.start = !pend_q;
				ureq.op    = OP_SQRT;
				ureq.count = CNT_SQRT;
				uopa       = {2'b00, s_q, 60'd0};
			end
			ST_R2: begin
				ureq.start = !pend_q;
				ureq.count = CNT_R2;
				uopa       = 128'(r_q);
				uopb       = 128'(r_q);
			end
			ST_FDIV: begin
				ureq.start = !pend_q;
				ureq.op    = OP_DIV;
				ureq.count = CNT_FDIV;
				uopa       = {km_q, 64'd0};
				uopb       = 128'(r2_q);
			end
			ST_FMUL: begin
				ureq.start = !pend_q;
				ureq.count = CNT_FMUL;
				uopa       = 128'(f_q);
				uopb       = 128'(absd);
			end
			ST_ADIV: begin
				ureq.start = !pend_q;
				ureq.op    = OP_DIV;
				ureq.count = CNT_ADIV;
				uopa       = {prod_q, 31'd0};
				uopb       = 128'(r_q);
			end
			default: ;
		endcase
	end

	assign m_tdata = {vel_q[2], vel_q[1], vel_q[0], pos_q[2], pos_q[1], pos_q[0]};
	assign m_tuser = status_q;

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ax_q     <= '0;
			pend_q   <= 1'b0;
			sat_q    <= 1'b0;
			status_q <= STAT_OK;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (ureq.start) pend_q <= 1'b1;
			else if (udone) pend_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (accept) begin
					ax_q     <= '0;
					sat_q    <= 1'b0;
					status_q <= STAT_OK;
					if (s_tuser[0] == CMD_RESTART) begin
						for (int i = 0; i < 3; i++) begin
							pos_q[i] <= init_q[i];
							vel_q[i] <= init_q[i+3];
						end
					end
				end
				ST_SQ: if (udone) ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
				ST_SQRT: if (udone && ures[33:0] == '0) status_q <= STAT_ZERO;
				ST_FDIV: if (udone && ures[127:64] != '0) sat_q <= 1'b1;
				ST_VEL: begin
					vel_q[ax_q] <= vnew;
					if (vsat) sat_q <= 1'b1;
					ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
				end
				ST_POS: begin
					pos_q[ax_q] <= pnew;
					if (ax_q == 2'd2) begin
						ax_q     <= '0;
						status_q <= (sat_q || psat) ? STAT_SAT : STAT_OK;
					end else begin
						ax_q <= ax_q + 2'd1;
						if (psat) sat_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (accept) begin
				d_q[0] <= 33'(signed'(s_tdata[31:0]))  - 33'(signed'(pos_q[0]));
				d_q[1] <= 33'(signed'(s_tdata[63:32])) - 33'(signed'(pos_q[1]));
				d_q[2] <= 33'(signed'(s_tdata[95:64])) - 33'(signed'(pos_q[2]));
				km_q   <= 64'(grav_q) * 64'(s_tdata[127:96]);
				s_q    <= '0;
			end
			ST_SQ:   if (udone) s_q <= s_q + ures[65:0];
			ST_SQRT: if (udone) r_q <= ures[33:0];
			ST_R2:   if (udone) r2_q <= ures[67:0];
			ST_FDIV: if (udone) f_q <= (ures[127:64] != '0) ? '1 : ures[63:0];
			ST_FMUL: if (udone) prod_q <= ures[96:0];
			ST_ADIV: if (udone) a_q <= ures[63:0];
			default: ;
		endcase
	end

endmodule

// ===== src/gebs_checker.sv =====
// Port-level checker for the gravity step core, bound to the top level.
`include "gravity_euler_body_step_core_macros.svh"

module gebs_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [191:0] m_tdata,
	input logic [1:0]   m_tuser
);
	import gebs_pkg::*;

	// busy right after an input transaction
	`GEBS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// no input while a result is offered
	`GEBS_ASSERT_NOW(a_no_overlap, clk, arst_n, m_tvalid, !s_tready)
	// one result per item
	`GEBS_ASSERT_NEXT(a_single_result, clk, arst_n, m_tvalid && m_tready, !m_tvalid)
	// stalled result holds
	`GEBS_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	// status code range
	`GEBS_ASSERT_NOW(a_status, clk, arst_n, m_tvalid,
		m_tuser == STAT_OK || m_tuser == STAT_ZERO || m_tuser == STAT_SAT)

endmodule

bind gravity_euler_body_step_core gebs_checker u_gebs_checker (.*);

// ===== verif/gravity_euler_body_step_core_tb.sv =====
// Self-checking testbench for the gravity step core: stream traffic, APB setup, predictor.
module gravity_euler_body_step_core_tb;
	import gebs_pkg::*;

	localparam int WATCHDOG_LIMIT = 6000;
	localparam logic CMD_STEP = ~CMD_RESTART;

	// predicted body state and configuration; expected results queue in order
	class body_scoreboard;
		longint pos [3];
		longint vel [3];
		bit [31:0] grav;
		bit [7:0] dt;
		bit [31:0] init_vals [6];
		bit [193:0] pending [$];
		int errors;

		function new();
			grav = 32'd65536;
			dt = 8'd5;
			foreach (init_vals[i]) init_vals[i] = '0;
			foreach (pos[i]) begin
				pos[i] = 0;
				vel[i] = 0;
			end
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, bit [31:0] val);
			case (idx)
				REG_GRAV: grav = val;
				REG_DT: dt = val[7:0];
				default: init_vals[idx - REG_POS_X] = val;
			endcase
		endfunction

		function longint clamp32(longint v, inout bit sat);
			if (v > 64'sd2147483647) begin
				sat = 1;
				return 64'sd2147483647;
			end
			if (v < -64'sd2147483648) begin
				sat = 1;
				return -64'sd2147483648;
			end
			return v;
		endfunction

		function bit [63:0] root_floor(bit [127:0] s);
			bit [63:0] r;
			bit [127:0] c;
			r = '0;
			for (int b = 63; b >= 0; b--) begin
				c = {64'd0, r | (64'd1 << b)};
				if (c * c <= s) r = c[63:0];
			end
			return r;
		endfunction

		// note one accepted input transaction and queue what it must produce
		function void note_input(logic cmd, bit [127:0] data);
			longint d [3];
			bit [63:0] mag [3];
			bit [127:0] sum, quot, prod;
			bit [63:0] r, f, a, delta;
			bit [1:0] status;
			bit sat;
			status = STAT_OK;
			sat = 0;
			if (cmd == CMD_RESTART) begin
				for (int i = 0; i < 3; i++) begin
					pos[i] = longint'($signed(init_vals[i]));
					vel[i] = longint'($signed(init_vals[i + 3]));
				end
			end else begin
				sum = '0;
				for (int i = 0; i < 3; i++) begin
					d[i] = longint'($signed(data[32*i +: 32])) - pos[i];
					mag[i] = d[i] < 0 ? -d[i] : d[i];
					sum += {64'd0, mag[i]} * {64'd0, mag[i]};
				end
				r = root_floor(sum);
				if (r == 0) begin
					status = STAT_ZERO;
				end else begin
					// kappa*mass scaled by 2^(2F), over r^2
					quot = ({64'd0, {32'd0, grav} * {32'd0, data[127:96]}} << (2 * FRAC_BITS))
						/ ({64'd0, r} * {64'd0, r});
					if (quot[127:64] != 0) begin
						f = '1;
						sat = 1;
					end else begin
						f = quot[63:0];
					end
					for (int i = 0; i < 3; i++) begin
						quot = ({64'd0, f} * {64'd0, mag[i]}) / {64'd0, r};
						a = quot[63:0];
						prod = {64'd0, a} * {120'd0, dt};
						delta = (prod > 128'h2_0000_0000) ? 64'h2_0000_0000 : prod[63:0];
						vel[i] = clamp32(d[i] < 0 ? vel[i] - longint'(delta)
							: vel[i] + longint'(delta), sat);
					end
					for (int i = 0; i < 3; i++)
						pos[i] = clamp32(pos[i] + vel[i] * longint'(dt), sat);
					if (sat) status = STAT_SAT;
				end
			end
			pending.push_back({status, vel[2][31:0], vel[1][31:0], vel[0][31:0],
				pos[2][31:0], pos[1][31:0], pos[0][31:0]});
		endfunction

		// compare one result transaction with the oldest expectation
		function void check_result(bit [191:0] data, bit [1:0] stat);
			bit [193:0] exp_item;
			string names [6];
			names = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z"};
			if (pending.size() == 0) begin
				$error("unexpected result transaction, tdata %h", data);
				errors++;
				return;
			end
			exp_item = pending.pop_front();
			for (int i = 0; i < 6; i++)
				if (exp_item[32*i +: 32] !== data[32*i +: 32]) begin
					$error("%s expected %h actual %h", names[i], exp_item[32*i +: 32],
						data[32*i +: 32]);
					errors++;
				end
			if (exp_item[193:192] !== stat) begin
				$error("status expected %0d actual %0d", exp_item[193:192], stat);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_tvalid, s_tready;
	logic [127:0] s_tdata;
	logic [0:0] s_tuser;
	logic m_tvalid, m_tready;
	logic [191:0] m_tdata;
	logic [1:0] m_tuser;
	logic psel, penable, pwrite, pready;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;

	body_scoreboard sb;
	bit no_idle;    // phases without gaps on either side
	int quiet_cycles;

	gravity_euler_body_step_core dut (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// idle gap for one transaction on either side
	function int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 12);
	endfunction

	function bit [31:0] span_rand();
		return $urandom >> $urandom_range(0, 31);
	endfunction

	task automatic apb_write(logic [2:0] idx, bit [31:0] val);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		// register takes the value at this edge
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		sb.write_reg(idx, val);
	endtask

	task automatic send_item(logic cmd, bit [127:0] data);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= cmd;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
		sb.note_input(cmd, data);
	endtask

	// drain: sender holds off until every expected result is back
	task automatic wait_drained();
		@(posedge clk);
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// attractor relative to the predicted body, mostly nearby, sometimes anywhere
	task automatic send_step(int kind);
		bit [127:0] data;
		for (int i = 0; i < 3; i++) begin
			case (kind)
				0: data[32*i +: 32] = sb.pos[i][31:0];
				1: data[32*i +: 32] = $urandom;
				default: data[32*i +: 32] = sb.pos[i][31:0] + span_rand()
					* ($urandom_range(0, 1) ? 1 : -1);
			endcase
		end
		data[127:96] = $urandom_range(0, 3) == 0 ? $urandom : span_rand();
		send_item(CMD_STEP, data);
	endtask

	task automatic random_item();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 2) send_item(CMD_RESTART, {$urandom, $urandom, $urandom, $urandom});
		else if (pick < 4) send_step(0);
		else if (pick < 6) send_step(1);
		else send_step(2);
	endtask

	// sink side with random stalls
	initial begin
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			int gap;
			gap = draw_gap();
			if (gap > 0) begin
				m_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_result(m_tdata, m_tuser);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		bit [31:0] grav_set [8];
		bit [7:0] dt_set [8];
		sb = new();
		quiet_cycles = 0;
		no_idle = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = CMD_RESTART;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed part, reset configuration
		send_item(CMD_RESTART, '0);
		send_item(CMD_STEP, '0);                                     // zero distance
		send_item(CMD_STEP, {32'd1, 32'd0, 32'd0, 32'h0001_0000});  // unit distance
		send_item(CMD_STEP, {32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
		send_item(CMD_STEP, {32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
		send_item(CMD_STEP, {32'd0, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF}); // no mass
		send_item(CMD_STEP, {32'hFFFF_FFFF, 32'd0, 32'd1, 32'd0});  // tiny distance, huge pull
		send_step(0);
		send_item(CMD_RESTART, '1);
		send_item(CMD_STEP, {32'd100, 32'h0010_0000, 32'hFFF0_0000, 32'h0008_0000});
		send_step(2);
		wait_drained();

		// settings per phase: extremes of kappa and time step, zero step included
		grav_set = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd65536, 32'h0000_0100,
			32'h0100_0000, 32'd3000, 32'h00FF_FFFF};
		dt_set = '{8'd1, 8'd255, 8'd0, 8'd1, 8'd5, 8'd17, 8'd255, 8'd2};
		for (int ph = 0; ph < 8; ph++) begin
			no_idle = (ph % 3 == 2);
			apb_write(REG_GRAV, grav_set[ph]);
			apb_write(REG_DT, dt_set[ph]);
			for (int k = 0; k < 6; k++)
				apb_write(3'(REG_POS_X + k), ph == 1 ? 32'h7FFF_FFFF : ph == 2 ? 32'h8000_0000
					: $urandom_range(0, 1) ? $urandom : span_rand());
			send_item(CMD_RESTART, {$urandom, $urandom, $urandom, $urandom});
			repeat (48) random_item();
			wait_drained();
		end

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
